// ===== design/lafs_pkg.sv =====
// Shared types and constants for the link atom force split pipeline.
package lafs_pkg;

    localparam int UNIT_SHIFT = 30;
    localparam int NORM_W     = 30;
    localparam int ROOT_W     = 31;
    localparam int UQ_W       = UNIT_SHIFT + 1;
    localparam int QDIV_W     = 44;
    localparam int CAP_LOG    = 40;

    typedef struct packed {
        logic signed [31:0] qm_x;
        logic signed [31:0] qm_y;
        logic signed [31:0] qm_z;
        logic signed [31:0] mm_x;
        logic signed [31:0] mm_y;
        logic signed [31:0] mm_z;
        logic signed [31:0] link_x;
        logic signed [31:0] link_y;
        logic signed [31:0] link_z;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] qm_delta_x;
        logic signed [31:0] qm_delta_y;
        logic signed [31:0] qm_delta_z;
        logic signed [31:0] mm_delta_x;
        logic signed [31:0] mm_delta_y;
        logic signed [31:0] mm_delta_z;
        logic               skipped;
        logic               saturated;
    } t_out;

endpackage

// ===== design/lafs_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
module lafs_isqrt #(
    parameter int OW = 31
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*OW-1:0] i_rad,
    output logic [OW-1:0]   o_root
);

    localparam int RW = OW + 2;

    logic [2*OW-1:0] r_rad  [OW];
    logic [RW-1:0]   r_rem  [OW];
    logic [OW-1:0]   r_root [OW];

    for (genvar s = 0; s < OW; s++) begin : g_stage
        logic [2*OW-1:0] rad_in;
        logic [RW-1:0]   rem_in;
        logic [OW-1:0]   root_in;
        logic [RW-1:0]   rem_sh;
        logic [RW-1:0]   trial;

        if (s == 0) begin : g_first
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign rad_in  = r_rad[s-1];
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
        end

        // Bring down the next pair of radicand bits and try root*4+1.
        assign rem_sh = {rem_in[RW-3:0], rad_in[2*OW-1 -: 2]};
        assign trial  = {root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[s] <= {rad_in[2*OW-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    r_rem[s]  <= rem_sh - trial;
                    r_root[s] <= {root_in[OW-2:0], 1'b1};
                end else begin
                    r_rem[s]  <= rem_sh;
                    r_root[s] <= {root_in[OW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[OW-1];

endmodule

// ===== design/lafs_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
module lafs_div #(
    parameter int NW = 60,
    parameter int DW = 31,
    parameter int QW = 31
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    // The caller keeps the numerator below den * 2^QW, so the top part
    // starts out below the divisor.
    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_low [QW];
    logic [QW-1:0] r_quo [QW];
    logic [DW-1:0] r_den [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] quo_in;
        logic [DW-1:0] den_in;
        logic [DW:0]   rem_sh;
        logic          take;

        if (s == 0) begin : g_first
            assign rem_in = DW'(i_num[NW-1:QW]);
            assign low_in = i_num[QW-1:0];
            assign quo_in = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign low_in = r_low[s-1];
            assign quo_in = r_quo[s-1];
            assign den_in = r_den[s-1];
        end

        assign rem_sh = {rem_in, low_in[QW-1]};
        assign take   = rem_sh >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_low[s] <= low_in << 1;
                r_den[s] <= den_in;
                r_quo[s] <= {quo_in[QW-2:0], take};
                r_rem[s] <= take ? DW'(rem_sh - {1'b0, den_in}) : DW'(rem_sh);
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

// ===== design/link_atom_force_split_top.sv =====
// Link atom force split: bond normalization, projection and scaled cross force.
// Throughput is one item per cycle; the whole pipeline advances together and
// holds while the output register is full and stalled.
// Depth is set by the bit-per-stage square roots (31), unit dividers (31) and
// scale dividers (44). Reset clears only the valid bits of the stages.
module link_atom_force_split_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  lafs_pkg::t_in    i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output lafs_pkg::t_out   o_data
);

    localparam int ROOT_W  = lafs_pkg::ROOT_W;
    localparam int UQ_W    = lafs_pkg::UQ_W;
    localparam int QDIV_W  = lafs_pkg::QDIV_W;
    localparam int NORM_W  = lafs_pkg::NORM_W;
    localparam int V_ROOT  = 3 + ROOT_W;
    localparam int V_UNIT  = V_ROOT + UQ_W;
    localparam int LAT     = 4 + ROOT_W + UQ_W + 9 + QDIV_W + 2;
    localparam logic [40:0] FMOD_CAP = 41'(1) << lafs_pkg::CAP_LOG;
    localparam logic [43:0] CAP44    = 44'(FMOD_CAP);
    localparam logic [30:0] UNIT_ONE = 31'(1) << lafs_pkg::UNIT_SHIFT;
    localparam logic signed [63:0] BIAS64 = (64'sd1 <<< lafs_pkg::UNIT_SHIFT) - 64'sd1;
    localparam logic signed [66:0] BIAS67 = (67'sd1 <<< lafs_pkg::UNIT_SHIFT) - 67'sd1;

    typedef struct packed {
        logic                    zero;
        logic [1:0]              kd;
        logic [1:0]              kl;
        logic [2:0]              dneg;
        logic [2:0][NORM_W-1:0]  dm;
        logic [2:0][31:0]        f;
    } t_front;

    typedef struct packed {
        logic              zero;
        logic [1:0]        kd;
        logic [1:0]        kl;
        logic [2:0]        dneg;
        logic [2:0][31:0]  f;
        logic [ROOT_W-1:0] dl;
        logic [ROOT_W-1:0] ll;
    } t_mid;

    typedef struct packed {
        logic             zero;
        logic [1:0]       kd;
        logic [1:0]       kl;
        logic [2:0]       fneg;
        logic [2:0]       ovf;
        logic [2:0][31:0] f;
    } t_tail;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic [1:0] norm_k(input logic [2:0][32:0] m);
        logic hi;
        logic mid;
        hi  = |{m[0][32:31], m[1][32:31], m[2][32:31]};
        mid = m[0][30] | m[1][30] | m[2][30];
        return hi ? 2'd2 : (mid ? 2'd1 : 2'd0);
    endfunction

    // Returns the clip flag above the clamped 32-bit value.
    function automatic logic [32:0] clamp32(input logic signed [42:0] x);
        if (x > 43'sd2147483647) begin
            return {1'b1, 32'h7fff_ffff};
        end
        if (x < -43'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, x[31:0]};
    endfunction

    logic w_en;
    logic [LAT-1:0] r_vld;

    assign w_en    = !r_vld[LAT-1] || !i_stall;
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Stage 1: bond and link vectors.
    logic signed [31:0] in_q [3];
    logic signed [31:0] in_m [3];
    logic signed [31:0] in_k [3];
    logic signed [31:0] in_f [3];
    logic signed [32:0] r1_d [3];
    logic signed [32:0] r1_l [3];
    logic signed [31:0] r1_f [3];

    assign in_q[0] = i_data.qm_x;
    assign in_q[1] = i_data.qm_y;
    assign in_q[2] = i_data.qm_z;
    assign in_m[0] = i_data.mm_x;
    assign in_m[1] = i_data.mm_y;
    assign in_m[2] = i_data.mm_z;
    assign in_k[0] = i_data.link_x;
    assign in_k[1] = i_data.link_y;
    assign in_k[2] = i_data.link_z;
    assign in_f[0] = i_data.force_x;
    assign in_f[1] = i_data.force_y;
    assign in_f[2] = i_data.force_z;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_d[i] <= 33'(in_m[i]) - 33'(in_q[i]);
                r1_l[i] <= 33'(in_k[i]) - 33'(in_q[i]);
                r1_f[i] <= in_f[i];
            end
        end
    end

    // Stage 2: scale both vectors so every component fits in 30 bits.
    logic [2:0][32:0]   n2_dmag;
    logic [2:0][32:0]   n2_lmag;
    logic [1:0]         n2_kd;
    logic [1:0]         n2_kl;
    t_front             n2_side;
    t_front             r2_side;
    logic [NORM_W-1:0]  r2_lm [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n2_dmag[i] = mag33(r1_d[i]);
            n2_lmag[i] = mag33(r1_l[i]);
        end
        n2_kd        = norm_k(n2_dmag);
        n2_kl        = norm_k(n2_lmag);
        n2_side.zero = (r1_d[0] == '0) && (r1_d[1] == '0) && (r1_d[2] == '0);
        n2_side.kd   = n2_kd;
        n2_side.kl   = n2_kl;
        for (int i = 0; i < 3; i++) begin
            n2_side.dneg[i] = r1_d[i][32];
            n2_side.dm[i]   = NORM_W'(n2_dmag[i] >> n2_kd);
            n2_side.f[i]    = r1_f[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_side <= n2_side;
            for (int i = 0; i < 3; i++) begin
                r2_lm[i] <= NORM_W'(n2_lmag[i] >> n2_kl);
            end
        end
    end

    // Stages 3 and 4: squared lengths.
    logic [2*NORM_W-1:0]   r3_dsq [3];
    logic [2*NORM_W-1:0]   r3_lsq [3];
    t_front                r3_side;
    logic [2*ROOT_W-1:0]   r4_d2;
    logic [2*ROOT_W-1:0]   r4_l2;
    t_front                r4_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r3_dsq[i] <= r2_side.dm[i] * r2_side.dm[i];
                r3_lsq[i] <= r2_lm[i] * r2_lm[i];
            end
            r3_side <= r2_side;
            r4_d2   <= (2*ROOT_W)'(r3_dsq[0]) + (2*ROOT_W)'(r3_dsq[1])
                       + (2*ROOT_W)'(r3_dsq[2]);
            r4_l2   <= (2*ROOT_W)'(r3_lsq[0]) + (2*ROOT_W)'(r3_lsq[1])
                       + (2*ROOT_W)'(r3_lsq[2]);
            r4_side <= r3_side;
        end
    end

    // Lengths, with the side data delayed to match.
    logic [ROOT_W-1:0] w_dl;
    logic [ROOT_W-1:0] w_ll;
    t_front            r_dly1 [ROOT_W];

    lafs_isqrt #(.OW(ROOT_W)) u_root_d (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r4_d2),
        .o_root (w_dl)
    );

    lafs_isqrt #(.OW(ROOT_W)) u_root_l (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r4_l2),
        .o_root (w_ll)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly1[0] <= r4_side;
            for (int i = 1; i < ROOT_W; i++) begin
                r_dly1[i] <= r_dly1[i-1];
            end
        end
    end

    // Unit vector component magnitudes in unsigned Q1.30.
    t_front           w_front;
    t_mid             n_mid;
    logic [UQ_W-1:0]  w_umag [3];
    t_mid             r_dly2 [UQ_W];

    assign w_front = r_dly1[ROOT_W-1];

    always_comb begin
        n_mid.zero = w_front.zero;
        n_mid.kd   = w_front.kd;
        n_mid.kl   = w_front.kl;
        n_mid.dneg = w_front.dneg;
        n_mid.f    = w_front.f;
        n_mid.dl   = w_dl;
        n_mid.ll   = w_ll;
    end

    for (genvar g = 0; g < 3; g++) begin : g_unit
        lafs_div #(.NW(NORM_W + lafs_pkg::UNIT_SHIFT), .DW(ROOT_W), .QW(UQ_W)) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num ({w_front.dm[g], lafs_pkg::UNIT_SHIFT'(0)}),
            .i_den (w_dl),
            .o_quo (w_umag[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly2[0] <= n_mid;
            for (int i = 1; i < UQ_W; i++) begin
                r_dly2[i] <= r_dly2[i-1];
            end
        end
    end

    // Projection stages: signed unit, F*u, dot, p, p*u, Fpar, Fperp, |Fperp|, *Ll.
    t_mid               r_pa_side, r_pb_side, r_pc_side, r_pd_side, r_pe_side;
    t_mid               r_pf_side, r_pg_side, r_ph_side, r_pi_side;
    logic signed [31:0] r_pa_u [3];
    logic signed [31:0] r_pb_u [3];
    logic signed [31:0] r_pc_u [3];
    logic signed [31:0] r_pd_u [3];
    logic signed [63:0] r_pb_fu [3];
    logic signed [63:0] r_pc_dot;
    logic signed [63:0] n_pd_sum;
    logic signed [34:0] r_pd_p;
    logic signed [66:0] r_pe_pu [3];
    logic signed [66:0] n_pf_sum [3];
    logic signed [36:0] r_pf_fpar [3];
    logic signed [37:0] r_pg_fperp [3];
    logic [36:0]        r_ph_fpm [3];
    logic [2:0]         r_ph_fneg;
    logic [2:0]         r_pi_fneg;
    logic [67:0]        n_pi_full [3];
    logic [63:0]        r_pi_prod [3];

    always_comb begin
        n_pd_sum = r_pc_dot + (r_pc_dot[63] ? BIAS64 : 64'sd0);
        for (int i = 0; i < 3; i++) begin
            n_pf_sum[i]  = r_pe_pu[i] + (r_pe_pu[i][66] ? BIAS67 : 67'sd0);
            n_pi_full[i] = {31'b0, r_ph_fpm[i]} * {37'b0, r_ph_side.ll};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pa_side <= r_dly2[UQ_W-1];
            for (int i = 0; i < 3; i++) begin
                r_pa_u[i] <= r_dly2[UQ_W-1].dneg[i] ? -$signed({1'b0, w_umag[i]})
                                                    : $signed({1'b0, w_umag[i]});
            end

            r_pb_side <= r_pa_side;
            r_pb_u    <= r_pa_u;
            for (int i = 0; i < 3; i++) begin
                r_pb_fu[i] <= $signed(r_pa_side.f[i]) * r_pa_u[i];
            end

            r_pc_side <= r_pb_side;
            r_pc_u    <= r_pb_u;
            r_pc_dot  <= r_pb_fu[0] + r_pb_fu[1] + r_pb_fu[2];

            // Shifts round toward zero: negative values get a bias first.
            r_pd_side <= r_pc_side;
            r_pd_u    <= r_pc_u;
            r_pd_p    <= 35'(n_pd_sum >>> lafs_pkg::UNIT_SHIFT);

            r_pe_side <= r_pd_side;
            for (int i = 0; i < 3; i++) begin
                r_pe_pu[i] <= r_pd_p * r_pd_u[i];
            end

            r_pf_side <= r_pe_side;
            for (int i = 0; i < 3; i++) begin
                r_pf_fpar[i] <= 37'(n_pf_sum[i] >>> lafs_pkg::UNIT_SHIFT);
            end

            r_pg_side <= r_pf_side;
            for (int i = 0; i < 3; i++) begin
                r_pg_fperp[i] <= 38'($signed(r_pf_side.f[i])) - 38'(r_pf_fpar[i]);
            end

            r_ph_side <= r_pg_side;
            for (int i = 0; i < 3; i++) begin
                r_ph_fneg[i] <= r_pg_fperp[i][37];
                r_ph_fpm[i]  <= r_pg_fperp[i][37] ? 37'(-r_pg_fperp[i])
                                                  : 37'(r_pg_fperp[i]);
            end

            r_pi_side <= r_ph_side;
            r_pi_fneg <= r_ph_fneg;
            for (int i = 0; i < 3; i++) begin
                r_pi_prod[i] <= n_pi_full[i][63:0];
            end
        end
    end

    // Scale by link length over bond length. A quotient of 2^44 or more is
    // past the cap whatever the shift, so only that flag is kept for it.
    t_tail             n_tail;
    t_tail             r_dly3 [QDIV_W];
    logic [QDIV_W-1:0] w_q [3];

    always_comb begin
        n_tail.zero = r_pi_side.zero;
        n_tail.kd   = r_pi_side.kd;
        n_tail.kl   = r_pi_side.kl;
        n_tail.fneg = r_pi_fneg;
        n_tail.f    = r_pi_side.f;
        for (int i = 0; i < 3; i++) begin
            n_tail.ovf[i] = {11'b0, r_pi_prod[i][63:QDIV_W]} >= r_pi_side.dl;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_scale
        lafs_div #(.NW(64), .DW(ROOT_W), .QW(QDIV_W)) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_pi_prod[g]),
            .i_den (r_pi_side.dl),
            .o_quo (w_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly3[0] <= n_tail;
            for (int i = 1; i < QDIV_W; i++) begin
                r_dly3[i] <= r_dly3[i-1];
            end
        end
    end

    // Final shift by the difference of the two normalization shifts, then cap.
    t_tail       w_tail;
    logic        w_up;
    logic [1:0]  w_sh;
    logic [43:0] w_lim;
    logic [43:0] n_f1_qs [3];
    logic [40:0] n_f1_m [3];
    logic [40:0] r_f1_m [3];
    t_tail       r_f1_tail;

    assign w_tail = r_dly3[QDIV_W-1];
    assign w_up   = w_tail.kl >= w_tail.kd;
    assign w_sh   = w_up ? 2'(w_tail.kl - w_tail.kd) : 2'(w_tail.kd - w_tail.kl);
    assign w_lim  = CAP44 >> w_sh;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_f1_qs[i] = w_q[i] >> w_sh;
            if (w_up) begin
                n_f1_m[i] = (w_tail.ovf[i] || (w_q[i] > w_lim)) ? FMOD_CAP
                                                                : 41'(w_q[i] << w_sh);
            end else begin
                n_f1_m[i] = (w_tail.ovf[i] || (n_f1_qs[i] > CAP44)) ? FMOD_CAP
                                                                    : 41'(n_f1_qs[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_m    <= n_f1_m;
            r_f1_tail <= w_tail;
        end
    end

    // Output stage: deltas, clamping and the skip override.
    logic signed [41:0] n_fmod [3];
    logic [32:0]        n_qc [3];
    logic [32:0]        n_mc [3];
    lafs_pkg::t_out     n_out;
    lafs_pkg::t_out     r_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_fmod[i] = r_f1_tail.fneg[i] ? -$signed({1'b0, r_f1_m[i]})
                                          : $signed({1'b0, r_f1_m[i]});
            n_qc[i]   = clamp32(43'($signed(r_f1_tail.f[i])) - 43'(n_fmod[i]));
            n_mc[i]   = clamp32(43'(n_fmod[i]));
        end
        if (r_f1_tail.zero) begin
            n_out         = '0;
            n_out.skipped = 1'b1;
        end else begin
            n_out.qm_delta_x = n_qc[0][31:0];
            n_out.qm_delta_y = n_qc[1][31:0];
            n_out.qm_delta_z = n_qc[2][31:0];
            n_out.mm_delta_x = n_mc[0][31:0];
            n_out.mm_delta_y = n_mc[1][31:0];
            n_out.mm_delta_z = n_mc[2][31:0];
            n_out.skipped    = 1'b0;
            n_out.saturated  = n_qc[0][32] | n_qc[1][32] | n_qc[2][32]
                               | n_mc[0][32] | n_mc[1][32] | n_mc[2][32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.skipped |-> !o_data.saturated
            && o_data.qm_delta_x == '0 && o_data.qm_delta_y == '0
            && o_data.qm_delta_z == '0 && o_data.mm_delta_x == '0
            && o_data.mm_delta_y == '0 && o_data.mm_delta_z == '0)
        else $error("skipped result carries nonzero deltas");

    a_bond_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[V_ROOT] && !w_front.zero |-> w_dl != '0)
        else $error("nonzero bond gave a zero length");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[V_UNIT] && !r_dly2[UQ_W-1].zero |->
            w_umag[0] <= UNIT_ONE && w_umag[1] <= UNIT_ONE && w_umag[2] <= UNIT_ONE)
        else $error("unit vector component above one");

endmodule
